@@ design/positional_array_list_top_macros.svh @@
// ---------------------------------------------------------------------------
// positional array list assertion macros
// shared concurrent assertion forms for the list blocks
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_ARRAY_LIST_TOP_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define PAL_ASSERT_IMP(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication, disabled during reset
`define PAL_ASSERT_NXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

@@ design/pal_pkg.sv @@
// ---------------------------------------------------------------------------
// pal_pkg
// types and constants shared by the positional array list blocks
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pal_pkg;

   localparam int POS_W     = 4;
   localparam int WORD_W    = 32;
   localparam int OUT_CNT_W = 5;
   localparam int OP_W      = 2;

   typedef enum logic [OP_W-1:0] {
      OP_READ   = 2'd0,
      OP_MODIFY = 2'd1,
      OP_INSERT = 2'd2,
      OP_REMOVE = 2'd3
   } pal_op_type;

   // command broadcast to every cell, enables already qualified by success
   typedef struct packed {
      logic                     modify_en;
      logic                     insert_en;
      logic                     remove_en;
      logic [POS_W-1:0]         position;
      logic signed [WORD_W-1:0] value;
   } pal_cmd_type;

   // result status of one item, after the operation
   typedef struct packed {
      logic                 ok;
      logic [OUT_CNT_W-1:0] count;
      logic                 is_empty;
      logic                 is_full;
   } pal_status_type;

endpackage

@@ design/pal_cell.sv @@
// ---------------------------------------------------------------------------
// pal_cell
// one list slot: loads from the lower neighbor, the upper neighbor,
// the new value or holds
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pal_cell
   import pal_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  logic                     clock,
   input  pal_cmd_type              cmd,
   input  logic signed [WORD_W-1:0] prev_word,
   input  logic signed [WORD_W-1:0] next_word,
   output logic signed [WORD_W-1:0] word
);

   logic signed [WORD_W-1:0] word_ff;
   logic signed [WORD_W-1:0] word_in;
   logic                     at_pos;
   logic                     above_pos;

   assign at_pos    = (32'(cmd.position) == 32'(INDEX));
   assign above_pos = (32'(INDEX) > 32'(cmd.position));

   always_comb begin
      word_in = word_ff;
      priority if (cmd.insert_en) begin
         if (at_pos) begin
            word_in = cmd.value;
         end else if (above_pos) begin
            word_in = prev_word;
         end
      end else if (cmd.remove_en) begin
         if (at_pos || above_pos) begin
            word_in = next_word;
         end
      end else if (cmd.modify_en) begin
         if (at_pos) begin
            word_in = cmd.value;
         end
      end else begin
         // no operation on the row this cycle
         word_in = word_ff;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

@@ design/pal_ctrl.sv @@
// ---------------------------------------------------------------------------
// pal_ctrl
// fill count, bounds checks and command decode for the cell row
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "positional_array_list_top_macros.svh"

module pal_ctrl
   import pal_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  pal_op_type               opcode,
   input  logic [POS_W-1:0]         position,
   input  logic signed [WORD_W-1:0] value,
   output pal_cmd_type              cmd,
   output pal_status_type           status
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] cnt_ext;
   logic             in_list;
   logic             not_full;
   logic             ok;

   assign pos_ext  = CMP_W'(position);
   assign cnt_ext  = CMP_W'(count_ff);
   assign in_list  = (pos_ext < cnt_ext);
   assign not_full = (count_ff != CNT_W'(CAPACITY));

   always_comb begin
      unique case (opcode)
         OP_READ:   ok = in_list;
         OP_MODIFY: ok = in_list;
         OP_INSERT: ok = not_full && (pos_ext <= cnt_ext);
         OP_REMOVE: ok = in_list;
         default:   ok = 1'b0;
      endcase
   end

   always_comb begin
      cmd.modify_en = accept && ok && (opcode == OP_MODIFY);
      cmd.insert_en = accept && ok && (opcode == OP_INSERT);
      cmd.remove_en = accept && ok && (opcode == OP_REMOVE);
      cmd.position  = position;
      cmd.value     = value;
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.insert_en) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.remove_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      status.ok       = ok;
      status.count    = OUT_CNT_W'(count_in);
      status.is_empty = (count_in == '0);
      status.is_full  = (count_in == CNT_W'(CAPACITY));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   `PAL_ASSERT_NXT(a_insert_grows, clock, reset, cmd.insert_en,
      count_ff == CNT_W'($past(count_ff) + 1'b1), "insert did not grow the list")
   `PAL_ASSERT_NXT(a_remove_shrinks, clock, reset, cmd.remove_en,
      count_ff == CNT_W'($past(count_ff) - 1'b1), "remove did not shrink the list")
   `PAL_ASSERT_NXT(a_refused_holds, clock, reset, accept && !ok,
      count_ff == $past(count_ff), "refused item changed the fill count")

endmodule

@@ design/positional_array_list_top.sv @@
// ---------------------------------------------------------------------------
// positional_array_list_top
// bounded ordered list of signed words with read, modify, insert and remove
// ---------------------------------------------------------------------------
// The list is a row of CAPACITY cells, one word each, plus a fill count.
// On acceptance of an item each cell loads from its lower
// neighbor (insert shifts up), its upper neighbor (remove shifts down), the
// item's value (insert or modify at the position) or keeps its word, and
// the result is captured in the output register the same edge. Items are
// taken one per cycle while the result side keeps up; the single output
// register holds a result that is not taken and stalls the request side
// until it goes. Read, modify and remove are refused when the position is
// not below the count, insert when the list is full or the position is
// beyond the count; a refused item leaves the list unchanged. read_value
// is zero except for a successful read. No clearing pass after reset:
// only slots below the count are ever read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "positional_array_list_top_macros.svh"

module positional_array_list_top
   import pal_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [OP_W-1:0]          req_opcode,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [WORD_W-1:0] req_value,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_ok,
   output logic signed [WORD_W-1:0] rsp_read_value,
   output logic [OUT_CNT_W-1:0]     rsp_count,
   output logic                     rsp_is_empty,
   output logic                     rsp_is_full
);

   // positions reach only the first cells of the row
   localparam int RD_N = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);

   pal_op_type               opcode;
   logic                     accept;
   pal_cmd_type              cmd;
   pal_status_type           status;
   logic signed [WORD_W-1:0] words [CAPACITY];
   logic signed [WORD_W-1:0] sel_word;
   logic signed [WORD_W-1:0] rd_word;

   // output register
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic                     rsp_ok_ff;
   logic signed [WORD_W-1:0] rsp_read_value_ff;
   logic [OUT_CNT_W-1:0]     rsp_count_ff;
   logic                     rsp_is_empty_ff;
   logic                     rsp_is_full_ff;

   assign opcode    = pal_op_type'(req_opcode);
   // only a held result that is not being taken blocks a new item
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   pal_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .opcode   (opcode),
      .position (req_position),
      .value    (req_value),
      .cmd      (cmd),
      .status   (status)
   );

   // row of cells, each wired to both neighbors; ends see zero
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [WORD_W-1:0] prev_word;
      logic signed [WORD_W-1:0] next_word;

      if (g == 0) begin : g_first
         assign prev_word = '0;
      end else begin : g_mid_lo
         assign prev_word = words[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
         assign next_word = '0;
      end else begin : g_mid_hi
         assign next_word = words[g+1];
      end

      pal_cell #(
         .INDEX (g)
      ) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .prev_word (prev_word),
         .next_word (next_word),
         .word      (words[g])
      );
   end

   // read port: select the addressed cell before the operation
   always_comb begin
      sel_word = '0;
      for (int i = 0; i < RD_N; i++) begin
         if (req_position == POS_W'(i)) begin
            sel_word = words[i];
         end
      end
   end

   assign rd_word = (status.ok && (opcode == OP_READ)) ? sel_word : '0;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, loaded only with a new item
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ok_ff         <= status.ok;
         rsp_read_value_ff <= rd_word;
         rsp_count_ff      <= status.count;
         rsp_is_empty_ff   <= status.is_empty;
         rsp_is_full_ff    <= status.is_full;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_is_empty   = rsp_is_empty_ff;
   assign rsp_is_full    = rsp_is_full_ff;

   // a refused item never carries read data
   `PAL_ASSERT_IMP(a_refused_no_data, clock, reset, rsp_valid_ff && !rsp_ok_ff,
      rsp_read_value_ff == '0, "refused item carries read data")
   // accepted non-read items report zero read data
   `PAL_ASSERT_NXT(a_nonread_no_data, clock, reset, accept && (opcode != OP_READ),
      rsp_read_value_ff == '0, "non-read item carries read data")
   // a stalled result stays valid and its count unchanged
   `PAL_ASSERT_NXT(a_stalled_holds, clock, reset, rsp_valid_ff && rsp_stall,
      rsp_valid_ff && $stable(rsp_count_ff), "stalled result changed")

endmodule
